// ----- rtl/core/ddo_pkg.sv -----
// ============================================================================
// ddo_pkg
// Shared types, constants and helper functions of the wheel odometry core.
// ============================================================================
package ddo_pkg;

    localparam int W          = 32;
    localparam int MOP_W      = 34;
    localparam int PROD_W     = 2 * MOP_W;
    localparam int ACC_W      = 36;
    localparam int ATAN_IDX_W = 5;

    typedef logic signed [W-1:0]      t_word;
    typedef logic        [W-1:0]      t_uword;
    typedef logic signed [MOP_W-1:0]  t_mop;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic        [1:0]        t_cfg_idx;

    localparam t_cfg_idx CFG_MPT  = 2'd0;
    localparam t_cfg_idx CFG_ISEP = 2'd1;
    localparam t_cfg_idx CFG_IPER = 2'd2;

    localparam t_uword MPT_RST  = 32'd429497;
    localparam t_uword ISEP_RST = 32'd186121;
    localparam t_uword IPER_RST = 32'd65536000;

    localparam t_acc PI_Q28       = 36'sd843314857;
    localparam t_acc TWO_PI_Q28   = 36'sd1686629714;
    localparam t_mop HALF_PI_Q28  = 34'sd421657428;
    localparam t_mop PI_Q28_M     = 34'sd843314857;
    localparam t_mop CORDIC_GAIN  = 34'sd652032874;

    localparam t_word SAT_MAX = 32'sh7FFF_FFFF;
    localparam t_word SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        SH_4,
        SH_16,
        SH_17,
        SH_30
    } t_shift;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DL,
        ST_DR,
        ST_GAP,
        ST_ROT,
        ST_VS,
        ST_VD,
        ST_VL,
        ST_VR,
        ST_CORDIC,
        ST_PX,
        ST_PY,
        ST_WRAP,
        ST_DONE
    } t_state;

    function automatic t_mop atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        t_mop v;
        unique case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837830;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            5'd31: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic t_word sat_acc(input t_acc v);
        t_word r;
        if (v > t_acc'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < t_acc'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // one correction step toward [-pi, pi)
    function automatic t_acc wrap_step(input t_acc v);
        t_acc r;
        if (v >= PI_Q28) begin
            r = v - TWO_PI_Q28;
        end else if (v < -PI_Q28) begin
            r = v + TWO_PI_Q28;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ddo_if.sv -----
// ============================================================================
// ddo interfaces
// Valid/ready channels of the odometry core: ticks in, pose out, config.
// ============================================================================
interface ddo_in_if #(
    parameter int TICK_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [TICK_BITS-1:0] left_ticks;
    logic signed [TICK_BITS-1:0] right_ticks;

    modport source (output valid, left_ticks, right_ticks, input ready);
    modport sink   (input valid, left_ticks, right_ticks, output ready);
endinterface

interface ddo_out_if;
    import ddo_pkg::*;
    logic  valid;
    logic  ready;
    t_word pos_x;
    t_word pos_y;
    t_word heading_out;
    t_word forward_speed;
    t_word rotation_speed;
    t_word left_speed;
    t_word right_speed;

    modport source (output valid, pos_x, pos_y, heading_out, forward_speed,
                    rotation_speed, left_speed, right_speed, input ready);
    modport sink   (input valid, pos_x, pos_y, heading_out, forward_speed,
                    rotation_speed, left_speed, right_speed, output ready);
endinterface

interface ddo_cfg_if;
    import ddo_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_uword   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ddo_mul.sv -----
// ============================================================================
// ddo_mul
// Shared signed multiplier with registered product, floor shift and
// 32-bit saturation.
// ============================================================================
module ddo_mul (
    input  logic           i_clk,
    input  logic           i_go,
    input  ddo_pkg::t_mop  i_a,
    input  ddo_pkg::t_mop  i_b,
    input  ddo_pkg::t_shift i_sh,
    output ddo_pkg::t_word o_sat,
    output ddo_pkg::t_mop  o_wide
);
    import ddo_pkg::*;

    t_prod  r_prod;
    t_shift r_sh;
    t_prod  w_prod;
    t_prod  w_shf;

    assign w_prod = t_prod'(i_a) * t_prod'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_prod <= w_prod;
            r_sh   <= i_sh;
        end
    end

    always_comb begin
        unique case (r_sh)
            SH_4:    w_shf = r_prod >>> 4;
            SH_16:   w_shf = r_prod >>> 16;
            SH_17:   w_shf = r_prod >>> 17;
            SH_30:   w_shf = r_prod >>> 30;
            default: w_shf = r_prod;
        endcase
    end

    always_comb begin
        if (w_shf[PROD_W-1:W-1] == '0 || w_shf[PROD_W-1:W-1] == '1) begin
            o_sat = w_shf[W-1:0];
        end else if (w_shf[PROD_W-1]) begin
            o_sat = SAT_MIN;
        end else begin
            o_sat = SAT_MAX;
        end
    end

    assign o_wide = w_shf[MOP_W-1:0];

endmodule

// ----- rtl/core/ddo_cordic.sv -----
// ============================================================================
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle; folds the
// angle into [-pi/2, pi/2] on start.
// ============================================================================
module ddo_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ddo_pkg::t_word i_ang,
    output logic          o_busy,
    output ddo_pkg::t_mop o_cos,
    output ddo_pkg::t_mop o_sin
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_flip;
    t_mop             r_x;
    t_mop             r_y;
    t_mop             r_z;

    t_mop w_a;
    t_mop w_fold;
    logic w_flip;
    t_mop w_dx;
    t_mop w_dy;
    t_mop w_at;

    always_comb begin
        w_a = t_mop'(i_ang);
        if (w_a > HALF_PI_Q28) begin
            w_fold = w_a - PI_Q28_M;
            w_flip = 1'b1;
        end else if (w_a < -HALF_PI_Q28) begin
            w_fold = w_a + PI_Q28_M;
            w_flip = 1'b1;
        end else begin
            w_fold = w_a;
            w_flip = 1'b0;
        end
    end

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;
    assign w_at = atan_q30(ATAN_IDX_W'(r_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= w_fold <<< 2;
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[MOP_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

// ----- rtl/core/differential_drive_odometry_top.sv -----
// ============================================================================
// differential_drive_odometry_top
// Wheel odometry: ticks to wheel travel, midpoint pose integration with an
// iterative CORDIC, heading wrap and speeds from a reciprocal period.
//
//   port    dir   payload                                    handshake
//   i_in    in    left_ticks, right_ticks                    valid/ready
//   o_out   out   pos_x, pos_y, heading_out, 4 speeds        valid/ready
//   i_cfg   in    index (0..2), data (32 bits)               valid/ready
//
// A transaction runs from one acceptance to the earliest next one through
// nine products on one shared multiplier plus the CORDIC loop.
// i_in.ready is high only while the sequencer is idle; a finished result
// sits in the output register, and the next item may already run.
// Sequencer waits at its last step while an earlier result is not taken.
// Synchronous active-low reset; pose clears to zero, registers to defaults;
// no channel is ready while reset is held.
// ============================================================================
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = 24,
    parameter int TICK_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ddo_in_if.sink    i_in,
    ddo_out_if.source o_out,
    ddo_cfg_if.sink   i_cfg
);
    import ddo_pkg::*;

    t_state r_state;
    t_state n_state;

    t_uword r_mpt;
    t_uword r_isep;
    t_uword r_iper;

    t_word r_pose_x;
    t_word r_pose_y;
    t_word r_heading;

    logic signed [TICK_BITS-1:0] r_tl;
    logic signed [TICK_BITS-1:0] r_tr;
    t_word r_dl;
    t_word r_dr;
    t_word r_rot;
    t_word r_vs;
    t_word r_vd;
    t_word r_vl;
    t_word r_vr;
    t_acc  r_ang;
    t_acc  r_hd;

    logic  r_ovalid;
    t_word r_o_x;
    t_word r_o_y;
    t_word r_o_h;
    t_word r_o_vs;
    t_word r_o_vd;
    t_word r_o_vl;
    t_word r_o_vr;

    logic   w_go;
    t_mop   w_a;
    t_mop   w_b;
    t_shift w_sh;
    t_word  w_msat;
    t_mop   w_mwide;
    logic   w_cstart;
    logic   w_cbusy;
    t_mop   w_cos;
    t_mop   w_sin;
    t_mop   w_sum;
    t_mop   w_diff;
    t_mop   w_fwd;
    logic   w_load;

    assign w_sum  = t_mop'(r_dl) + t_mop'(r_dr);
    assign w_diff = t_mop'(r_dr) - t_mop'(r_dl);
    assign w_fwd  = w_sum >>> 1;
    assign w_load = (r_state == ST_DONE) && (!r_ovalid || o_out.ready);

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_go   (w_go),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_sh   (w_sh),
        .o_sat  (w_msat),
        .o_wide (w_mwide)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_ang   (r_ang[W-1:0]),
        .o_busy  (w_cbusy),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_go     = 1'b0;
        w_a      = '0;
        w_b      = '0;
        w_sh     = SH_4;
        w_cstart = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_DL;
                end
            end
            ST_DL: begin
                w_go    = 1'b1;
                w_a     = t_mop'(r_tl);
                w_b     = t_mop'(r_mpt);
                w_sh    = SH_16;
                n_state = ST_DR;
            end
            ST_DR: begin
                w_go    = 1'b1;
                w_a     = t_mop'(r_tr);
                w_b     = t_mop'(r_mpt);
                w_sh    = SH_16;
                n_state = ST_GAP;
            end
            ST_GAP: begin
                n_state = ST_ROT;
            end
            ST_ROT: begin
                w_go    = 1'b1;
                w_a     = w_diff;
                w_b     = t_mop'(r_isep);
                w_sh    = SH_4;
                n_state = ST_VS;
            end
            ST_VS: begin
                w_go    = 1'b1;
                w_a     = w_sum;
                w_b     = t_mop'(r_iper);
                w_sh    = SH_17;
                n_state = ST_VD;
            end
            ST_VD: begin
                w_go    = 1'b1;
                w_a     = w_diff;
                w_b     = t_mop'(r_iper);
                w_sh    = SH_17;
                n_state = ST_VL;
            end
            ST_VL: begin
                w_go    = 1'b1;
                w_a     = t_mop'(r_dl);
                w_b     = t_mop'(r_iper);
                w_sh    = SH_16;
                n_state = ST_VR;
            end
            ST_VR: begin
                w_go     = 1'b1;
                w_a      = t_mop'(r_dr);
                w_b      = t_mop'(r_iper);
                w_sh     = SH_16;
                w_cstart = 1'b1;
                n_state  = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (!w_cbusy) begin
                    n_state = ST_PX;
                end
            end
            ST_PX: begin
                w_go    = 1'b1;
                w_a     = w_fwd;
                w_b     = w_cos;
                w_sh    = SH_30;
                n_state = ST_PY;
            end
            ST_PY: begin
                w_go    = 1'b1;
                w_a     = w_fwd;
                w_b     = w_sin;
                w_sh    = SH_30;
                n_state = ST_WRAP;
            end
            ST_WRAP: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control, config and pose
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt     <= MPT_RST;
            r_isep    <= ISEP_RST;
            r_iper    <= IPER_RST;
            r_pose_x  <= '0;
            r_pose_y  <= '0;
            r_heading <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MPT:  r_mpt  <= i_cfg.data;
                    CFG_ISEP: r_isep <= i_cfg.data;
                    CFG_IPER: r_iper <= i_cfg.data;
                    default:  ;
                endcase
            end
            if (r_state == ST_PY) begin
                r_pose_x <= sat_acc(t_acc'(r_pose_x) + t_acc'(w_mwide));
            end
            if (r_state == ST_WRAP) begin
                r_pose_y <= sat_acc(t_acc'(r_pose_y) + t_acc'(w_mwide));
            end
            if (w_load) begin
                r_heading <= r_hd[W-1:0];
                r_ovalid  <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_tl <= i_in.left_ticks;
                r_tr <= i_in.right_ticks;
            end
            ST_DR: r_dl <= w_msat;
            ST_GAP: r_dr <= w_msat;
            ST_VS: r_rot <= w_msat;
            ST_VD: begin
                r_vs  <= w_msat;
                r_ang <= t_acc'(r_heading) + (t_acc'(r_rot) >>> 1);
            end
            ST_VL: begin
                r_vd  <= w_msat;
                r_ang <= wrap_step(r_ang);
            end
            ST_VR: r_vl <= w_msat;
            ST_CORDIC: begin
                r_vr <= w_msat;
                r_hd <= t_acc'(r_heading) + t_acc'(r_rot);
            end
            ST_PX: r_hd <= wrap_step(r_hd);
            ST_PY: r_hd <= wrap_step(r_hd);
            default: ;
        endcase
        if (w_load) begin
            r_o_x  <= r_pose_x;
            r_o_y  <= r_pose_y;
            r_o_h  <= r_hd[W-1:0];
            r_o_vs <= r_vs;
            r_o_vd <= r_vd;
            r_o_vl <= r_vl;
            r_o_vr <= r_vr;
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE) && i_rst_n;
    assign i_cfg.ready          = i_rst_n;
    assign o_out.valid          = r_ovalid;
    assign o_out.pos_x          = r_o_x;
    assign o_out.pos_y          = r_o_y;
    assign o_out.heading_out    = r_o_h;
    assign o_out.forward_speed  = r_o_vs;
    assign o_out.rotation_speed = r_o_vd;
    assign o_out.left_speed     = r_o_vl;
    assign o_out.right_speed    = r_o_vr;

endmodule
